// ===== design/hbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hbs_pkg;

	// Default side of the height store
	localparam int MAX_DIM_DEF = 256;

	// Configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 24;

	localparam logic [CFG_AW-1:0] REG_HALF_EXTENT    = 3'd0;
	localparam logic [CFG_AW-1:0] REG_EXTENT_MAX     = 3'd1;
	localparam logic [CFG_AW-1:0] REG_PIXELS_PER_UNIT = 3'd2;
	localparam logic [CFG_AW-1:0] REG_IMAGE_SIZE     = 3'd3;
	localparam logic [CFG_AW-1:0] REG_BASE_ELEVATION = 3'd4;
	localparam logic [CFG_AW-1:0] REG_ELEVATION_SPAN = 3'd5;

	// Bilinear corner weight, Q1.16 so that 1.0 is representable
	localparam int WT_W = 17;

	// Request from the address front end to the height store
	typedef struct packed {
		logic valid;
		logic lookup;
		logic wr_en;
	} mem_req_t;

	// Tag that travels with each height read
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} rd_tag_t;

endpackage

`default_nettype wire

// ===== design/hbs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hbs_front #(
	parameter int MAX_DIM = hbs_pkg::MAX_DIM_DEF,
	localparam int IW = $clog2(MAX_DIM),
	localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic                    op,
	input  logic [7:0]              pixel_row,
	input  logic [7:0]              pixel_col,
	input  logic [7:0]              pixel_value,
	input  logic signed [15:0]      x_pos,
	input  logic signed [15:0]      y_pos,
	input  logic [15:0]             half_extent,
	input  logic [15:0]             extent_max,
	input  logic [15:0]             pixels_per_unit,
	input  logic [8:0]              image_size,
	output hbs_pkg::mem_req_t       req,
	output logic [AW-1:0]           addr [4],
	output logic [hbs_pkg::WT_W-1:0] wt [4],
	output logic [7:0]              wdata
);

	import hbs_pkg::*;

	// Stage 1: captured item
	logic        v_s1, lookup_s1;
	logic [15:0] x_s1, y_s1;
	logic [7:0]  prow_s1, pcol_s1, pval_s1;

	// Stage 2: clamped world offsets and weights
	logic            v_s2, lookup_s2, wen_s2;
	logic [15:0]     t_s2 [4];
	logic [WT_W-1:0] w_s2 [4];
	logic [AW-1:0]   waddr_s2;
	logic [7:0]      pval_s2;

	// Stage 3: scaled pixel indexes
	logic            v_s3, lookup_s3, wen_s3;
	logic [15:0]     p_s3 [4];
	logic [WT_W-1:0] w_s3 [4];
	logic [AW-1:0]   waddr_s3;
	logic [7:0]      pval_s3;

	// Stage 4: memory addresses
	logic            v_s4, lookup_s4, wen_s4;
	logic [AW-1:0]   addr_s4 [4];
	logic [WT_W-1:0] w_s4 [4];
	logic [7:0]      pval_s4;

	logic signed [8:0] crd [4];
	logic [17:0]       tsum [4];
	logic [15:0]       tcl [4];
	logic [8:0]        xr, yr;
	logic [17:0]       wp [4];
	logic              wr_ok;
	logic [AW-1:0]     waddr;
	logic [31:0]       sprod [4];
	logic [IW-1:0]     nm1;
	logic [IW-1:0]     pc [4];
	logic [IW-1:0]     row0, row1;
	logic [AW-1:0]     addr_n [4];

	// Advance the valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Capture the item on its transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			lookup_s1 <= op;
			x_s1      <= x_pos;
			y_s1      <= y_pos;
			prow_s1   <= pixel_row;
			pcol_s1   <= pixel_col;
			pval_s1   <= pixel_value;
		end
	end

	// Split into corners, offset by half the extent and clamp; form weights
	always_comb begin
		crd[0] = {x_s1[15], x_s1[15:8]};
		crd[1] = crd[0] + 9'sd1;
		crd[2] = {y_s1[15], y_s1[15:8]};
		crd[3] = crd[2] + 9'sd1;
		for (int i = 0; i < 4; i++) begin
			tsum[i] = {crd[i][8], crd[i], 8'h00} + {2'b00, half_extent};
			if (tsum[i][17])
				tcl[i] = 16'd0;
			else if (tsum[i][16:0] > {1'b0, extent_max})
				tcl[i] = extent_max;
			else
				tcl[i] = tsum[i][15:0];
		end
		xr = 9'd256 - {1'b0, x_s1[7:0]};
		yr = 9'd256 - {1'b0, y_s1[7:0]};
		wp[0] = {9'd0, xr} * {9'd0, yr};
		wp[1] = {10'd0, x_s1[7:0]} * {9'd0, yr};
		wp[2] = {9'd0, xr} * {10'd0, y_s1[7:0]};
		wp[3] = {10'd0, x_s1[7:0]} * {10'd0, y_s1[7:0]};
		wr_ok = (32'(prow_s1) < MAX_DIM) && (32'(pcol_s1) < MAX_DIM);
		waddr = AW'(32'(prow_s1) * MAX_DIM + 32'(pcol_s1));
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			lookup_s2 <= lookup_s1;
			wen_s2    <= !lookup_s1 && wr_ok;
			waddr_s2  <= waddr;
			pval_s2   <= pval_s1;
			for (int i = 0; i < 4; i++) begin
				t_s2[i] <= tcl[i];
				w_s2[i] <= wp[i][WT_W-1:0];
			end
		end
	end

	// Scale by pixels per unit and truncate
	always_comb begin
		for (int i = 0; i < 4; i++)
			sprod[i] = {16'd0, t_s2[i]} * {16'd0, pixels_per_unit};
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			lookup_s3 <= lookup_s2;
			wen_s3    <= wen_s2;
			waddr_s3  <= waddr_s2;
			pval_s3   <= pval_s2;
			for (int i = 0; i < 4; i++) begin
				p_s3[i] <= sprod[i][31:16];
				w_s3[i] <= w_s2[i];
			end
		end
	end

	// Clamp to the image, flip rows and form the four addresses; a write puts its address first
	always_comb begin
		if (image_size == 9'd0)
			nm1 = '0;
		else if (32'(image_size) > MAX_DIM)
			nm1 = IW'(MAX_DIM - 1);
		else
			nm1 = IW'(image_size - 9'd1);
		for (int i = 0; i < 4; i++) begin
			if (p_s3[i] > 16'(nm1))
				pc[i] = nm1;
			else
				pc[i] = p_s3[i][IW-1:0];
		end
		row0 = nm1 - pc[2];
		row1 = nm1 - pc[3];
		addr_n[0] = AW'(32'(row0) * MAX_DIM + 32'(pc[0]));
		addr_n[1] = AW'(32'(row0) * MAX_DIM + 32'(pc[1]));
		addr_n[2] = AW'(32'(row1) * MAX_DIM + 32'(pc[0]));
		addr_n[3] = AW'(32'(row1) * MAX_DIM + 32'(pc[1]));
		if (!lookup_s3)
			addr_n[0] = waddr_s3;
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			lookup_s4 <= lookup_s3;
			wen_s4    <= wen_s3;
			pval_s4   <= pval_s3;
			for (int i = 0; i < 4; i++) begin
				addr_s4[i] <= addr_n[i];
				w_s4[i]    <= w_s3[i];
			end
		end
	end

	assign req.valid  = v_s4;
	assign req.lookup = lookup_s4;
	assign req.wr_en  = wen_s4;
	assign addr       = addr_s4;
	assign wt         = w_s4;
	assign wdata      = pval_s4;

endmodule

`default_nettype wire

// ===== design/hbs_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hbs_store #(
	parameter int MAX_DIM = hbs_pkg::MAX_DIM_DEF,
	localparam int DEPTH = MAX_DIM * MAX_DIM,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  hbs_pkg::mem_req_t        req,
	input  logic [AW-1:0]            addr [4],
	input  logic [hbs_pkg::WT_W-1:0] wt [4],
	input  logic [7:0]               wdata,
	output logic [7:0]               rdata,
	output hbs_pkg::rd_tag_t         tag,
	output logic [hbs_pkg::WT_W-1:0] rd_wt
);

	import hbs_pkg::*;

	logic [7:0]      mem [DEPTH];
	logic [1:0]      ph_q;
	logic            issue;
	logic            we;
	logic [AW-1:0]   maddr;
	logic [7:0]      rdata_q;
	rd_tag_t         tag_q;
	logic [WT_W-1:0] rd_wt_q;

	// One port access per cycle: a write, or one of four corner reads
	assign issue = (req.valid && req.lookup) || (ph_q != 2'd0);
	assign we    = req.valid && req.wr_en;
	assign maddr = addr[ph_q];

	// Step through the corners and tag each read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= 2'd0;
			tag_q <= '0;
		end else begin
			if (req.valid && req.lookup)
				ph_q <= 2'd1;
			else if (ph_q != 2'd0)
				ph_q <= ph_q + 2'd1;
			tag_q.valid <= issue;
			tag_q.first <= issue && (ph_q == 2'd0);
			tag_q.last  <= issue && (ph_q == 2'd3);
		end
	end

	// Carry the corner weight beside its read
	always_ff @(posedge clk) begin
		if (issue)
			rd_wt_q <= wt[ph_q];
	end

	// Height memory, single port
	always_ff @(posedge clk) begin
		if (we)
			mem[maddr] <= wdata;
		if (issue)
			rdata_q <= mem[maddr];
	end

	assign rdata = rdata_q;
	assign tag   = tag_q;
	assign rd_wt = rd_wt_q;

endmodule

`default_nettype wire

// ===== design/hbs_blend.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hbs_blend (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [7:0]               rdata,
	input  hbs_pkg::rd_tag_t         tag,
	input  logic [hbs_pkg::WT_W-1:0] rd_wt,
	input  logic signed [23:0]       base_elevation,
	input  logic signed [23:0]       elevation_span,
	output logic                     done,
	output logic signed [24:0]       elevation
);

	import hbs_pkg::*;

	// Half of 255 * 65536, for round to nearest
	localparam logic [47:0] RND_HALF = 48'd8355840;
	// ceil(2^39 / 255): exact quotient by 255 below 2^32
	localparam logic [31:0] RECIP_255 = 32'd2155905153;
	localparam logic signed [25:0] ELEV_MAX = 26'sd16777215;
	localparam logic signed [25:0] ELEV_MIN = -26'sd16777216;

	logic [24:0]  prod;
	logic [23:0]  prod_s1;
	logic         v_s1, first_s1, last_s1;
	logic [23:0]  acc_q;
	logic         v_s2;
	logic [23:0]  span_mag;
	logic [47:0]  mag_s3;
	logic         v_s3, neg_s3;
	logic [47:0]  rsum;
	logic [31:0]  q1_s4;
	logic         v_s4, neg_s4;
	logic [63:0]  r_s5;
	logic         v_s5, neg_s5;
	logic [23:0]  dmag;
	logic signed [25:0] delta, esum;
	logic [24:0]  esat;
	logic         done_q;
	logic [24:0]  elevation_q;

	// Weight each height
	assign prod = {17'd0, rdata} * {8'd0, rd_wt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= tag.valid;
			v_s2   <= v_s1 && last_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			done_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (tag.valid) begin
			prod_s1  <= prod[23:0];
			first_s1 <= tag.first;
			last_s1  <= tag.last;
		end
	end

	// Accumulate the four corners
	always_ff @(posedge clk) begin
		if (v_s1)
			acc_q <= (first_s1 ? 24'd0 : acc_q) + prod_s1;
	end

	// Scale by the span magnitude
	assign span_mag = elevation_span[23] ? 24'(-elevation_span) : 24'(elevation_span);

	always_ff @(posedge clk) begin
		if (v_s2) begin
			mag_s3 <= {24'd0, acc_q} * {24'd0, span_mag};
			neg_s3 <= elevation_span[23];
		end
	end

	// Round and drop the 65536 part of the divisor
	assign rsum = mag_s3 + RND_HALF;

	always_ff @(posedge clk) begin
		if (v_s3) begin
			q1_s4  <= rsum[47:16];
			neg_s4 <= neg_s3;
		end
	end

	// Divide by 255 through the reciprocal
	always_ff @(posedge clk) begin
		if (v_s4) begin
			r_s5   <= {32'd0, q1_s4} * {32'd0, RECIP_255};
			neg_s5 <= neg_s4;
		end
	end

	// Apply sign, add base and saturate
	always_comb begin
		dmag  = r_s5[62:39];
		delta = neg_s5 ? -$signed({2'b00, dmag}) : $signed({2'b00, dmag});
		esum  = $signed({{2{base_elevation[23]}}, base_elevation}) + delta;
		if (esum > ELEV_MAX)
			esat = ELEV_MAX[24:0];
		else if (esum < ELEV_MIN)
			esat = ELEV_MIN[24:0];
		else
			esat = esum[24:0];
	end

	always_ff @(posedge clk) begin
		if (v_s5)
			elevation_q <= esat;
	end

	assign done      = done_q;
	assign elevation = elevation_q;

endmodule

`default_nettype wire

// ===== design/heightmap_bilinear_sample.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+----------------------------------------------
// item in   | start / busy         | op, pixel_row, pixel_col, pixel_value, x_pos, y_pos
// result    | done (one cycle)     | elevation
// config    | cfg_we               | cfg_addr, cfg_wdata
//
// An item transfers at a clock edge with start high and busy low.
// A lookup holds the single-port height memory for its four corner reads, so busy stays
// high after its transfer to keep the next lookup off the port; a pixel write leaves
// busy low. The lookup result is strobed by done after the front, store and blend stages.
// Reset sets the registers to their defaults; the height memory is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.

module heightmap_bilinear_sample #(
	parameter int MAX_DIM = hbs_pkg::MAX_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         op,
	input  logic [7:0]                   pixel_row,
	input  logic [7:0]                   pixel_col,
	input  logic [7:0]                   pixel_value,
	input  logic signed [15:0]           x_pos,
	input  logic signed [15:0]           y_pos,
	input  logic                         cfg_we,
	input  logic [hbs_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [hbs_pkg::CFG_DW-1:0]   cfg_wdata,
	output logic                         done,
	output logic signed [24:0]           elevation
);

	import hbs_pkg::*;

	localparam int AW = $clog2(MAX_DIM * MAX_DIM);

	logic [1:0]        busy_cnt_q;
	logic              accept;
	logic [15:0]       half_extent_q, extent_max_q, ppu_q;
	logic [8:0]        image_size_q;
	logic signed [23:0] base_q, span_q;

	mem_req_t          req;
	logic [AW-1:0]     req_addr [4];
	logic [WT_W-1:0]   req_wt [4];
	logic [7:0]        req_wdata;
	logic [7:0]        rdata;
	rd_tag_t           rtag;
	logic [WT_W-1:0]   rd_wt;

	assign accept = start && !busy;
	assign busy   = (busy_cnt_q != 2'd0);

	// Hold off new items while a lookup owns the memory port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_cnt_q <= 2'd0;
		end else if (accept && op) begin
			busy_cnt_q <= 2'd3;
		end else if (busy_cnt_q != 2'd0) begin
			busy_cnt_q <= busy_cnt_q - 2'd1;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_extent_q <= 16'd2048;
			extent_max_q  <= 16'd3840;
			ppu_q         <= 16'd4096;
			image_size_q  <= 9'd256;
			base_q        <= 24'sd0;
			span_q        <= 24'sd25600;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_HALF_EXTENT:     half_extent_q <= cfg_wdata[15:0];
				REG_EXTENT_MAX:      extent_max_q  <= cfg_wdata[15:0];
				REG_PIXELS_PER_UNIT: ppu_q         <= cfg_wdata[15:0];
				REG_IMAGE_SIZE:      image_size_q  <= cfg_wdata[8:0];
				REG_BASE_ELEVATION:  base_q        <= cfg_wdata;
				REG_ELEVATION_SPAN:  span_q        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	hbs_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.op             (op),
		.pixel_row      (pixel_row),
		.pixel_col      (pixel_col),
		.pixel_value    (pixel_value),
		.x_pos          (x_pos),
		.y_pos          (y_pos),
		.half_extent    (half_extent_q),
		.extent_max     (extent_max_q),
		.pixels_per_unit(ppu_q),
		.image_size     (image_size_q),
		.req            (req),
		.addr           (req_addr),
		.wt             (req_wt),
		.wdata          (req_wdata)
	);

	hbs_store #(
		.MAX_DIM(MAX_DIM)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.addr  (req_addr),
		.wt    (req_wt),
		.wdata (req_wdata),
		.rdata (rdata),
		.tag   (rtag),
		.rd_wt (rd_wt)
	);

	hbs_blend u_blend (
		.clk           (clk),
		.arst_n        (arst_n),
		.rdata         (rdata),
		.tag           (rtag),
		.rd_wt         (rd_wt),
		.base_elevation(base_q),
		.elevation_span(span_q),
		.done          (done),
		.elevation     (elevation)
	);

endmodule

`default_nettype wire
